@@ rtl/core/inr64_pkg.sv @@
// Package for the integer n-th root block: microcode format, codes and program ROM.
package inr64_pkg;

	// Width of the microcode step counter.
	localparam int UPC_W = 4;

	// Datapath operations selected by a control word.
	localparam logic [3:0] OP_WAIT = 4'd0;
	localparam logic [3:0] OP_SEED = 4'd1;
	localparam logic [3:0] OP_MLO  = 4'd2;
	localparam logic [3:0] OP_MHI  = 4'd3;
	localparam logic [3:0] OP_ACC  = 4'd4;
	localparam logic [3:0] OP_NOP  = 4'd5;
	localparam logic [3:0] OP_KEEP = 4'd6;
	localparam logic [3:0] OP_NEXT = 4'd7;
	localparam logic [3:0] OP_DONE = 4'd8;

	// Jump conditions; when a condition is false the program falls through.
	localparam logic [2:0] C_NONE    = 3'd0;
	localparam logic [2:0] C_ALWAYS  = 3'd1;
	localparam logic [2:0] C_NOSTART = 3'd2;
	localparam logic [2:0] C_SKIP    = 3'd3;
	localparam logic [2:0] C_OVER    = 3'd4;
	localparam logic [2:0] C_MORE    = 3'd5;
	localparam logic [2:0] C_GT      = 3'd6;
	localparam logic [2:0] C_BITNZ   = 3'd7;

	// Program addresses.
	localparam logic [UPC_W-1:0] S_WAIT = 4'd0;
	localparam logic [UPC_W-1:0] S_SEED = 4'd1;
	localparam logic [UPC_W-1:0] S_MLO  = 4'd2;
	localparam logic [UPC_W-1:0] S_MHI  = 4'd3;
	localparam logic [UPC_W-1:0] S_ACC  = 4'd4;
	localparam logic [UPC_W-1:0] S_LOOP = 4'd5;
	localparam logic [UPC_W-1:0] S_TEST = 4'd6;
	localparam logic [UPC_W-1:0] S_KEEP = 4'd7;
	localparam logic [UPC_W-1:0] S_NEXT = 4'd8;
	localparam logic [UPC_W-1:0] S_DONE = 4'd9;

	// One control word of the program.
	typedef struct packed {
		logic [3:0]       op;
		logic [2:0]       cond;
		logic [UPC_W-1:0] target;
	} ucode_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic       load;
		logic [3:0] op;
	} ctl_t;

	// Flags from the datapath that the jump conditions test.
	typedef struct packed {
		logic skip;
		logic over;
		logic more;
		logic gt;
		logic bitnz;
	} stat_t;

	// Program ROM: one candidate root bit per pass from SEED to NEXT.
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
		ucode_t w;
		begin
			case (addr)
				S_WAIT:  w = '{op: OP_WAIT, cond: C_NOSTART, target: S_WAIT};
				S_SEED:  w = '{op: OP_SEED, cond: C_SKIP,    target: S_TEST};
				S_MLO:   w = '{op: OP_MLO,  cond: C_NONE,    target: S_WAIT};
				S_MHI:   w = '{op: OP_MHI,  cond: C_NONE,    target: S_WAIT};
				S_ACC:   w = '{op: OP_ACC,  cond: C_OVER,    target: S_NEXT};
				S_LOOP:  w = '{op: OP_NOP,  cond: C_MORE,    target: S_MLO};
				S_TEST:  w = '{op: OP_NOP,  cond: C_GT,      target: S_NEXT};
				S_KEEP:  w = '{op: OP_KEEP, cond: C_NONE,    target: S_WAIT};
				S_NEXT:  w = '{op: OP_NEXT, cond: C_BITNZ,   target: S_SEED};
				S_DONE:  w = '{op: OP_DONE, cond: C_ALWAYS,  target: S_WAIT};
				default: w = '{op: OP_NOP,  cond: C_ALWAYS,  target: S_WAIT};
			endcase
			return w;
		end
	endfunction

endpackage

@@ rtl/core/inr64_dp.sv @@
// Datapath of the integer n-th root block: operand registers, split multiplier, compares.
module inr64_dp import inr64_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                            clk,
	input  logic [63:0]                     radicand,
	input  logic [7:0]                      root_degree,
	input  ctl_t                            ctl,
	output stat_t                           stat,
	output logic [(DATA_WIDTH+1)/2-1:0]     root_bits
);

	localparam int HALF  = (DATA_WIDTH + 1) / 2;
	localparam int HI_W  = DATA_WIDTH - HALF;
	localparam int BIT_W = $clog2(HALF);
	localparam int PLO_W = 2 * HALF;
	localparam int PW    = DATA_WIDTH + HALF;

	logic [DATA_WIDTH-1:0] x_q;
	logic [7:0]            n_q;
	logic [7:0]            cnt_q;
	logic [HALF-1:0]       r_q;
	logic [HALF-1:0]       cand_q;
	logic [BIT_W-1:0]      b_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [PLO_W-1:0]      plo_q;
	logic [DATA_WIDTH-1:0] phi_q;

	logic [HALF-1:0]       cand_c;
	logic [HALF-1:0]       acc_lo;
	logic [HI_W-1:0]       acc_hi;
	logic [PW-1:0]         prod;

	// Candidate is the root so far with the current bit set.
	assign cand_c = r_q | (HALF'(1) << b_q);

	// The accumulator times the candidate, taken as two narrow partial products.
	assign acc_lo = acc_q[HALF-1:0];
	assign acc_hi = acc_q[DATA_WIDTH-1:HALF];
	assign prod   = {phi_q, {HALF{1'b0}}} + PW'(plo_q);

	// Flags for the sequencer's jumps.
	assign stat.skip  = (n_q == 8'd0) || (cand_c == HALF'(1));
	assign stat.over  = prod > PW'(x_q);
	assign stat.more  = cnt_q != 8'd0;
	assign stat.gt    = acc_q > x_q;
	assign stat.bitnz = b_q != '0;

	assign root_bits = r_q;

	// Register updates for each microcode operation.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q   <= radicand[DATA_WIDTH-1:0];
			n_q   <= root_degree;
			r_q   <= '0;
			b_q   <= BIT_W'(HALF - 1);
		end else begin
			case (ctl.op)
				OP_SEED: begin
					cand_q <= cand_c;
					acc_q  <= DATA_WIDTH'(1);
					cnt_q  <= n_q;
				end
				OP_MLO: begin
					plo_q <= PLO_W'(acc_lo) * PLO_W'(cand_q);
				end
				OP_MHI: begin
					phi_q <= DATA_WIDTH'(acc_hi) * DATA_WIDTH'(cand_q);
				end
				OP_ACC: begin
					// A power past the radicand only grows, so the candidate fails here.
					if (!stat.over) begin
						acc_q <= prod[DATA_WIDTH-1:0];
						cnt_q <= cnt_q - 8'd1;
					end
				end
				OP_KEEP: begin
					r_q <= cand_q;
				end
				OP_NEXT: begin
					b_q <= b_q - BIT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/integer_nth_root_64.sv @@
// Top level of the integer n-th root block: microcode sequencer and datapath.
//
// Pulse start while busy is low to hand in an item (radicand, root_degree); the block
// returns root, the largest value whose root_degree-th power does not exceed the radicand,
// with a one-cycle done strobe that the receiver must take as it comes. One item is
// worked on at a time: busy stays high from the accept until the done strobe. The root is
// found one bit at a time over (DATA_WIDTH+1)/2 candidate bits, and every power is built by
// repeated multiplication; each product is formed from two narrow partial products in
// the MLO and MHI steps and summed in the ACC step, then the LOOP step repeats until all
// n products are done. Each candidate bit starts with SEED; a product that passes the
// radicand rejects the candidate at once, and after all n products TEST keeps it through
// KEEP; NEXT then moves on to the next bit, and DONE follows the last one. When the degree
// is zero or the candidate is one, SEED skips the products and goes straight to TEST.
module integer_nth_root_64 import inr64_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	input  logic [7:0]  root_degree,
	output logic        busy,
	output logic        done,
	output logic [31:0] root
);

	localparam int HALF = (DATA_WIDTH + 1) / 2;

	logic [UPC_W-1:0] upc_q;
	logic             done_q;
	ucode_t           word;
	ctl_t             ctl;
	stat_t            stat;
	logic             jump;
	logic [HALF-1:0]  root_bits;

	// Fetch the control word of the current step.
	assign word = ucode_rom(upc_q);

	assign ctl.load = (word.op == OP_WAIT) && start;
	assign ctl.op   = word.op;

	// Evaluate the jump condition of the current word.
	always_comb begin
		case (word.cond)
			C_NONE:    jump = 1'b0;
			C_ALWAYS:  jump = 1'b1;
			C_NOSTART: jump = !start;
			C_SKIP:    jump = stat.skip;
			C_OVER:    jump = stat.over;
			C_MORE:    jump = stat.more;
			C_GT:      jump = stat.gt;
			C_BITNZ:   jump = stat.bitnz;
			default:   jump = 1'b1;
		endcase
	end

	// Step counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= S_WAIT;
			done_q <= 1'b0;
		end else begin
			upc_q  <= jump ? word.target : upc_q + UPC_W'(1);
			done_q <= (word.op == OP_DONE);
		end
	end

	inr64_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.radicand    (radicand),
		.root_degree (root_degree),
		.ctl         (ctl),
		.stat        (stat),
		.root_bits   (root_bits)
	);

	assign busy = upc_q != S_WAIT;
	assign done = done_q;
	assign root = 32'(root_bits);

endmodule

@@ rtl/core/inr64_checker.sv @@
// Port-level checks on the integer n-th root block, bound to its top level.
module inr64_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// An accepted item makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after an accepted item");

	// No result appears right after an item is accepted.
	a_accept_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result strobe right after accept");

	// The block is free again while it shows a result.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Each item gives a single one-cycle strobe.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind integer_nth_root_64 inr64_checker u_inr64_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
